FILE: rtl/core/nre_pkg.sv
// ----------------------------------------------------------------------------
// nre_pkg
// shared types, field positions and helpers of the nack request expander
// ----------------------------------------------------------------------------
`default_nettype none

package nre_pkg;

  localparam int NRE_SEQ_W       = 16;
  localparam int NRE_TIME_W      = 64;
  // candidate ids per nack: the packet id plus one per follow mask bit
  localparam int NRE_RUN_LEN     = NRE_SEQ_W + 1;
  localparam int NRE_IDX_W       = $clog2(NRE_RUN_LEN);
  localparam int NRE_QUEUE_DEPTH = 2;

  // input tdata layout, lowest bit first
  localparam int NRE_IN_READY_LSB = 0;
  localparam int NRE_IN_SEQ_LSB   = 1;
  localparam int NRE_IN_MASK_LSB  = NRE_IN_SEQ_LSB + NRE_SEQ_W;
  localparam int NRE_IN_TIME_LSB  = NRE_IN_MASK_LSB + NRE_SEQ_W;
  localparam int NRE_IN_RTT_LSB   = NRE_IN_TIME_LSB + NRE_TIME_W;
  localparam int NRE_IN_KEY_LSB   = NRE_IN_RTT_LSB + NRE_TIME_W;
  localparam int NRE_IN_USED_W    = NRE_IN_KEY_LSB + NRE_SEQ_W;
  localparam int NRE_IN_DATA_W    = ((NRE_IN_USED_W + 7) / 8) * 8;
  localparam int NRE_OUT_DATA_W   = NRE_SEQ_W;

  localparam logic [NRE_SEQ_W-1:0] NRE_HALF_RANGE = 16'h8000;

  typedef logic [NRE_SEQ_W-1:0] nre_seq_t;

  // one expansion job: base id and which offsets are to be sent
  typedef struct packed {
    nre_seq_t               seq;
    logic [NRE_RUN_LEN-1:0] send;
  } nre_job_t;

  // id lies before the key frame in serial-number order
  function automatic logic nre_before_key(input nre_seq_t key, input nre_seq_t id);
    nre_seq_t d;
    d = key - id;
    return (d != '0) && (d < NRE_HALF_RANGE);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nre_front.sv
// ----------------------------------------------------------------------------
// nre_front
// accepts nacks, filters repeats, records the answered nack, builds jobs
// ----------------------------------------------------------------------------
`default_nettype none

module nre_front
  import nre_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [NRE_IN_DATA_W-1:0] in_tdata,
  input  wire logic                    q_full,
  output logic                         q_push,
  output nre_job_t                     q_job
);

  logic                  ready_bit;
  nre_seq_t              lost_seq;
  nre_seq_t              follow_mask;
  logic [NRE_TIME_W-1:0] arrival_time;
  logic [NRE_TIME_W-1:0] round_trip;
  nre_seq_t              key_seq;
  logic [NRE_TIME_W-1:0] elapsed;
  logic                  is_repeat;
  logic                  answer;
  logic                  accept;
  logic [NRE_RUN_LEN-1:0] wanted;
  logic [NRE_RUN_LEN-1:0] send;

  nre_seq_t              ans_seq_r;
  nre_seq_t              ans_mask_r;
  logic [NRE_TIME_W-1:0] ans_time_r;

  assign ready_bit    = in_tdata[NRE_IN_READY_LSB];
  assign lost_seq     = in_tdata[NRE_IN_SEQ_LSB  +: NRE_SEQ_W];
  assign follow_mask  = in_tdata[NRE_IN_MASK_LSB +: NRE_SEQ_W];
  assign arrival_time = in_tdata[NRE_IN_TIME_LSB +: NRE_TIME_W];
  assign round_trip   = in_tdata[NRE_IN_RTT_LSB  +: NRE_TIME_W];
  assign key_seq      = in_tdata[NRE_IN_KEY_LSB  +: NRE_SEQ_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // elapsed time wraps modulo 2^64
  assign elapsed   = arrival_time - ans_time_r;
  assign is_repeat = (lost_seq == ans_seq_r) && (follow_mask == ans_mask_r) &&
                     (elapsed < round_trip);
  assign answer    = ready_bit && !is_repeat;

  assign wanted = {follow_mask, 1'b1};

  always_comb begin
    for (int i = 0; i < NRE_RUN_LEN; i++) begin
      send[i] = wanted[i] && !nre_before_key(key_seq, lost_seq + NRE_SEQ_W'(i));
    end
  end

  assign q_push     = accept && answer && (send != '0);
  assign q_job.seq  = lost_seq;
  assign q_job.send = send;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ans_seq_r  <= '0;
      ans_mask_r <= '0;
      ans_time_r <= '0;
    end else if (accept && answer) begin
      ans_seq_r  <= lost_seq;
      ans_mask_r <= follow_mask;
      ans_time_r <= arrival_time;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nre_queue.sv
// ----------------------------------------------------------------------------
// nre_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module nre_queue
  import nre_pkg::*;
#(
  parameter int DEPTH = NRE_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire nre_job_t push_job,
  output logic          full,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output nre_job_t      pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nre_job_t        slots [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nre_back.sv
// ----------------------------------------------------------------------------
// nre_back
// walks one job offset by offset and emits the resend requests
// ----------------------------------------------------------------------------
`default_nettype none

module nre_back
  import nre_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire nre_job_t                  q_job,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [NRE_OUT_DATA_W-1:0]      out_tdata,
  output logic                           out_tlast
);

  logic                   busy_r;
  nre_seq_t               seq_r;
  logic [NRE_RUN_LEN-1:0] pend_r;
  logic [NRE_IDX_W-1:0]   idx_r;
  logic                   out_valid_r;
  nre_seq_t               out_seq_r;
  logic                   out_last_r;

  logic slot_free;
  logic cur;
  logic last;
  logic stall;
  logic emit;

  assign slot_free = !out_valid_r || out_tready;
  // pend_r is shifted so bit 0 is always the current offset
  assign cur   = pend_r[0];
  assign last  = (pend_r[NRE_RUN_LEN-1:1] == '0);
  assign stall = cur && !slot_free;
  assign emit  = busy_r && cur && slot_free;

  assign q_ready    = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_seq_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (!busy_r) begin
      busy_r <= q_valid;
    end else if (!stall && last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      seq_r  <= q_job.seq;
      pend_r <= q_job.send;
      idx_r  <= '0;
    end else if (!stall) begin
      pend_r <= pend_r >> 1;
      idx_r  <= idx_r + NRE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seq_r  <= seq_r + NRE_SEQ_W'(idx_r);
      out_last_r <= last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nack_request_expander_top.sv
// ----------------------------------------------------------------------------
// nack_request_expander_top
// expands a generic nack (packet id plus follow mask) into resend requests
// ----------------------------------------------------------------------------
// usage:
//   in_*  stream carries one received nack per transfer; in_tready is high
//         whenever the job queue has room, dropped nacks are taken too
//   out_* stream carries one resend id per transfer, out_tlast marks the
//         last request caused by a nack; nacks that produce nothing give
//         no transfer at all
// path: with the back end idle a nack is written to the queue, loaded by the
//   back end and registered at the output; skipped leading offsets add delay
// throughput: the back end loads a job, then steps through its offsets up to
//   the highest offset still to send before it takes the next job;
//   the front takes one nack per cycle while the queue has room
// repeats: the answered id, mask and time are updated at the front as each
//   answered nack is taken, so repeat filtering follows input order
// reset: synchronous rst_n clears the answered nack state, the queue and
//   the output register
// stall: a held out_tready freezes the back end on its current request;
//   the queue fills and then in_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module nack_request_expander_top
  import nre_pkg::*;
#(
  parameter int QUEUE_DEPTH = NRE_QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // sender_ready, lost_seq, follow_mask, arrival_time, round_trip, key_frame_seq
  input  wire logic [NRE_IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // resend_seq
  output logic [NRE_OUT_DATA_W-1:0]      out_tdata,
  output logic                           out_tlast
);

  nre_job_t push_job;
  nre_job_t pop_job;
  logic     push;
  logic     full;
  logic     pop_valid;
  logic     pop_ready;

  nre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  nre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  nre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_job      (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
